[rtl/oqrk_pkg.sv]
// ----------------------------------------------------------------------------
// oqrk_pkg - shared types for the ordered queue with remove by key
// Request and result layouts, command and status codes, sequencer states.
// ----------------------------------------------------------------------------
package oqrk_pkg;

    localparam int ID_W = 17;

    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_DUMP   = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_EMPTY     = 2'd3
    } status_t;

    typedef struct packed {
        cmd_t            command;
        logic [ID_W-1:0] ident;
    } req_t;

    typedef struct packed {
        status_t         status;
        logic [ID_W-1:0] entry_ident;
        logic            last_of_run;
    } rsp_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH_RD,
        S_SEARCH_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_DUMP_RD,
        S_DUMP_OUT
    } state_t;

endpackage

[rtl/oqrk_ram.sv]
// ----------------------------------------------------------------------------
// oqrk_ram - generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module oqrk_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/ordered_queue_remove_by_key.sv]
// ----------------------------------------------------------------------------
// ordered_queue_remove_by_key - ordered line of identifiers
// Append at tail, remove first match from head with gap closing, dump in
// order. Entries live in one RAM walked by a small sequencer that compares
// its index against the occupancy.
// ----------------------------------------------------------------------------
//  channel  | signals             | handshake
//  ---------+---------------------+------------------------------------------
//  request  | start, busy, req    | taken when start is high and busy is low
//  result   | valid, result       | one cycle per result, no back-pressure
//
//  Result of a request appears in the cycle after the last work cycle.
//  Append: busy stays low.
//  Remove: a read and a compare per entry searched, then a read and a write per entry moved up (RAM port).
//  Dump: a read and an output step per held entry (registered RAM read), one result each.
//  Reset empties the line; the RAM itself is not cleared.
// ----------------------------------------------------------------------------
module ordered_queue_remove_by_key #(
    parameter int DEPTH   = 64,
    parameter int ID_BITS = 17
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  oqrk_pkg::req_t  req,
    output logic            valid,
    output oqrk_pkg::rsp_t  result
);

    import oqrk_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int OW = $clog2(DEPTH + 1);

    state_t              state_reg, state_next;
    logic [AW-1:0]       idx_reg, idx_next;
    logic [OW-1:0]       occ_reg, occ_next;
    logic [ID_BITS-1:0]  key_reg, key_next;
    logic                valid_reg, valid_next;
    rsp_t                rsp_reg, rsp_next;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [ID_BITS-1:0]  ram_wdata;
    logic [AW-1:0]       ram_raddr;
    logic [ID_BITS-1:0]  ram_rdata;

    logic [OW-1:0]       idx_p1;
    logic [OW-1:0]       idx_p2;
    logic                accept;

    oqrk_ram #(
        .WIDTH (ID_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;
    assign idx_p1 = OW'(idx_reg) + OW'(1);
    assign idx_p2 = OW'(idx_reg) + OW'(2);
    assign valid  = valid_reg;
    assign result = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            occ_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        key_reg <= key_next;
        rsp_reg <= rsp_next;
    end

    always_comb
    begin
        state_next           = state_reg;
        idx_next             = idx_reg;
        occ_next             = occ_reg;
        key_next             = key_reg;
        valid_next           = 1'b0;
        rsp_next.status      = ST_OK;
        rsp_next.entry_ident = '0;
        rsp_next.last_of_run = 1'b1;
        ram_we               = 1'b0;
        ram_waddr            = idx_reg;
        ram_wdata            = ram_rdata;
        ram_raddr            = idx_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                idx_next = '0;
                if (accept)
                begin
                    key_next = ID_BITS'(req.ident);
                    case (req.command)
                        CMD_APPEND:
                        begin
                            valid_next = 1'b1;
                            if (occ_reg == OW'(DEPTH))
                            begin
                                rsp_next.status = ST_FULL;
                            end
                            else
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = AW'(occ_reg);
                                ram_wdata = ID_BITS'(req.ident);
                                occ_next  = occ_reg + OW'(1);
                            end
                        end
                        CMD_REMOVE:
                        begin
                            if (occ_reg == '0)
                            begin
                                valid_next      = 1'b1;
                                rsp_next.status = ST_NOT_FOUND;
                            end
                            else
                            begin
                                state_next = S_SEARCH_RD;
                            end
                        end
                        CMD_DUMP:
                        begin
                            if (occ_reg == '0)
                            begin
                                valid_next      = 1'b1;
                                rsp_next.status = ST_EMPTY;
                            end
                            else
                            begin
                                state_next = S_DUMP_RD;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_SEARCH_RD:
            begin
                state_next = S_SEARCH_CMP;
            end
            S_SEARCH_CMP:
            begin
                if (ram_rdata == key_reg)
                begin
                    if (idx_p1 == occ_reg)
                    begin
                        occ_next   = occ_reg - OW'(1);
                        valid_next = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_SHIFT_RD;
                    end
                end
                else if (idx_p1 == occ_reg)
                begin
                    valid_next      = 1'b1;
                    rsp_next.status = ST_NOT_FOUND;
                    state_next      = S_IDLE;
                end
                else
                begin
                    idx_next   = AW'(idx_p1);
                    state_next = S_SEARCH_RD;
                end
            end
            S_SHIFT_RD:
            begin
                ram_raddr  = AW'(idx_p1);
                state_next = S_SHIFT_WR;
            end
            S_SHIFT_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg;
                ram_wdata = ram_rdata;
                if (idx_p2 == occ_reg)
                begin
                    occ_next   = occ_reg - OW'(1);
                    valid_next = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next   = AW'(idx_p1);
                    state_next = S_SHIFT_RD;
                end
            end
            S_DUMP_RD:
            begin
                state_next = S_DUMP_OUT;
            end
            S_DUMP_OUT:
            begin
                valid_next           = 1'b1;
                rsp_next.entry_ident = ID_W'(ram_rdata);
                if (idx_p1 == occ_reg)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    rsp_next.last_of_run = 1'b0;
                    idx_next             = AW'(idx_p1);
                    state_next           = S_DUMP_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OW'(DEPTH))
        else $error("occupancy above depth");

    a_done_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> valid)
        else $error("request finished without a result");

    a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
        accept && req.command == CMD_APPEND && occ_reg != OW'(DEPTH)
        |=> occ_reg == $past(occ_reg) + OW'(1))
        else $error("append did not grow the line");

    a_dump_continues: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !result.last_of_run |-> busy)
        else $error("dump stopped before its last entry");

    a_unused_silent: assert property (@(posedge clk) disable iff (!rst_n)
        accept && req.command != CMD_APPEND && req.command != CMD_REMOVE &&
        req.command != CMD_DUMP |=> !valid && !busy)
        else $error("unused command produced activity");

endmodule
